@@ src/wmf_pkg.sv @@
package wmf_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 13;

    localparam int ROWS_CFG_W  = 11;
    localparam int COLS_CFG_W  = 13;
    localparam int WIN_CFG_W   = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_ROWS    = 8'd0,
        CFG_IMAGE_COLS    = 8'd1,
        CFG_WINDOW_WIDTH  = 8'd2,
        CFG_WINDOW_HEIGHT = 8'd3
    } t_cfg_index;

    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET  = 11'd1024;
    localparam logic [COLS_CFG_W-1:0] COLS_RESET  = 13'd1024;
    localparam logic [WIN_CFG_W-1:0]  WIN_RESET   = 3'd3;

endpackage

@@ src/window_median_filter_2d.sv @@
// An accepted input word passes the stage 1, 2 and 3 registers and the output register to its result word.
// Throughput: one pixel word per cycle; the whole pipeline freezes only while a result
// word waits under i_stall, and the median is resolved by a parallel rank count.
// Reset (synchronous, active low): position goes to (0, 0), configuration returns to
// 1024 rows, 1024 columns and a 3 by 3 window, and all valid bits clear.
// The column stores and the window registers are not cleared and hold garbage until written.
module window_median_filter_2d #(
    parameter int MAX_ROWS   = 1024,
    parameter int MAX_COLS   = 4096,
    parameter int MAX_WINDOW = 7,
    parameter int PIXEL_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // pixel input channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [PIXEL_BITS-1:0]           i_pixel,
    input  logic                            i_frame_start,
    // result output channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [PIXEL_BITS-1:0]           o_median_value,
    output logic [$clog2(MAX_COLS)-1:0]     o_centre_col,
    output logic [$clog2(MAX_ROWS)-1:0]     o_centre_row,
    output logic                            o_frame_last,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [wmf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [wmf_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import wmf_pkg::*;

    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int SLOTS   = MAX_WINDOW - 1;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int T_W     = SLOT_W + 2;
    localparam int WIN_MAX = (MAX_WINDOW - 1) | 1;
    localparam int WS_W    = $clog2(WIN_MAX + 1);
    localparam int NVAL    = MAX_WINDOW * MAX_WINDOW;
    localparam int CNT_W   = $clog2(NVAL + 1);

    // ------------------------------------------------------------------
    // Configuration registers; always ready, as the user (not the block) ensures writes come while idle
    // ------------------------------------------------------------------
    logic [ROWS_CFG_W-1:0] r_cfg_rows;
    logic [COLS_CFG_W-1:0] r_cfg_cols;
    logic [WIN_CFG_W-1:0]  r_cfg_ww;
    logic [WIN_CFG_W-1:0]  r_cfg_wh;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rows <= ROWS_RESET;
            r_cfg_cols <= COLS_RESET;
            r_cfg_ww   <= WIN_RESET;
            r_cfg_wh   <= WIN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IMAGE_ROWS:    r_cfg_rows <= i_cfg_data[ROWS_CFG_W-1:0];
                CFG_IMAGE_COLS:    r_cfg_cols <= i_cfg_data[COLS_CFG_W-1:0];
                CFG_WINDOW_WIDTH:  r_cfg_ww   <= i_cfg_data[WIN_CFG_W-1:0];
                CFG_WINDOW_HEIGHT: r_cfg_wh   <= i_cfg_data[WIN_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective sizes: zero acts as one, clamp to the maximum; windows made odd.
    logic [ROW_W:0] rows_eff;
    logic [COL_W:0] cols_eff;
    logic [WS_W-1:0] ww_eff;
    logic [WS_W-1:0] wh_eff;

    always_comb begin
        if (r_cfg_rows == '0)
            rows_eff = (ROW_W+1)'(1);
        else if (32'(r_cfg_rows) > MAX_ROWS)
            rows_eff = (ROW_W+1)'(MAX_ROWS);
        else
            rows_eff = (ROW_W+1)'(r_cfg_rows);

        if (r_cfg_cols == '0)
            cols_eff = (COL_W+1)'(1);
        else if (32'(r_cfg_cols) > MAX_COLS)
            cols_eff = (COL_W+1)'(MAX_COLS);
        else
            cols_eff = (COL_W+1)'(r_cfg_cols);

        if (32'(r_cfg_ww | 3'd1) > WIN_MAX)
            ww_eff = WS_W'(WIN_MAX);
        else
            ww_eff = WS_W'(r_cfg_ww | 3'd1);

        if (32'(r_cfg_wh | 3'd1) > WIN_MAX)
            wh_eff = WS_W'(WIN_MAX);
        else
            wh_eff = WS_W'(r_cfg_wh | 3'd1);
    end

    // ------------------------------------------------------------------
    // Pipeline advance: hold everything only while a result word is stalled
    // ------------------------------------------------------------------
    logic r_out_valid;
    logic advance;
    logic accept;

    assign advance = !r_out_valid || !i_stall;
    assign o_stall = !advance;
    assign accept  = i_valid && advance;

    // ------------------------------------------------------------------
    // Stage 0: position of the incoming pixel, column store access
    // ------------------------------------------------------------------
    logic [ROW_W-1:0]  r_row_pos;
    logic [COL_W-1:0]  r_col_pos;
    logic [SLOT_W-1:0] r_slot;

    logic [ROW_W-1:0]  c_row;
    logic [COL_W:0]    c_col;
    logic [SLOT_W-1:0] c_slot;
    logic [ROW_W:0]    row_inc;
    logic [COL_W:0]    col_inc;
    logic [ROW_W-1:0]  n_row_pos;
    logic [COL_W-1:0]  n_col_pos;
    logic [SLOT_W-1:0] n_slot;
    logic [SLOT_W-1:0] slot_inc;

    always_comb begin
        c_row  = i_frame_start ? '0 : r_row_pos;
        c_col  = i_frame_start ? '0 : {1'b0, r_col_pos};
        c_slot = i_frame_start ? '0 : r_slot;
        // wrap a position left past the image after the size shrank
        if ({1'b0, c_row} >= rows_eff) begin
            c_row  = '0;
            c_col  = c_col + 1'b1;
            c_slot = (c_slot == SLOT_W'(SLOTS - 1)) ? '0 : c_slot + 1'b1;
        end
        if (c_col >= cols_eff) begin
            c_col  = '0;
            c_slot = '0;
        end

        row_inc  = {1'b0, c_row} + 1'b1;
        col_inc  = c_col + 1'b1;
        slot_inc = (c_slot == SLOT_W'(SLOTS - 1)) ? '0 : c_slot + 1'b1;

        // advance to the next pixel position
        if (row_inc >= rows_eff) begin
            n_row_pos = '0;
            if (col_inc >= cols_eff) begin
                n_col_pos = '0;
                n_slot    = '0;
            end else begin
                n_col_pos = col_inc[COL_W-1:0];
                n_slot    = slot_inc;
            end
        end else begin
            n_row_pos = row_inc[ROW_W-1:0];
            n_col_pos = c_col[COL_W-1:0];
            n_slot    = c_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_pos <= '0;
            r_col_pos <= '0;
            r_slot    <= '0;
        end else if (accept) begin
            r_row_pos <= n_row_pos;
            r_col_pos <= n_col_pos;
            r_slot    <= n_slot;
        end
    end

    // One line store per previous column, addressed by row; slot follows col mod SLOTS.
    logic [PIXEL_BITS-1:0] r_rd [SLOTS];

    for (genvar g = 0; g < SLOTS; g++) begin : g_store
        logic [PIXEL_BITS-1:0] mem [MAX_ROWS];

        always_ff @(posedge i_clk) begin
            if (accept && (c_slot == SLOT_W'(g)))
                mem[c_row] <= i_pixel;
            if (advance)
                r_rd[g] <= mem[c_row];
        end
    end

    // stage 1 registers
    logic                  r1_valid;
    logic [PIXEL_BITS-1:0] r1_pix;
    logic [SLOT_W-1:0]     r1_slot;
    logic [WS_W-1:0]       r1_ww;
    logic [WS_W-1:0]       r1_wh;
    logic                  r1_emit;
    logic                  r1_last;
    logic [COL_W-1:0]      r1_ccol;
    logic [ROW_W-1:0]      r1_crow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (advance) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r1_pix  <= i_pixel;
            r1_slot <= c_slot;
            r1_ww   <= ww_eff;
            r1_wh   <= wh_eff;
            r1_emit <= (col_inc >= (COL_W+1)'(ww_eff)) && (row_inc >= (ROW_W+1)'(wh_eff));
            r1_last <= (row_inc == rows_eff) && (col_inc == cols_eff);
            r1_ccol <= c_col[COL_W-1:0] - COL_W'(ww_eff >> 1);
            r1_crow <= c_row - ROW_W'(wh_eff >> 1);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: build the newest window row and shift the window
    // ------------------------------------------------------------------
    logic [PIXEL_BITS-1:0] r_win [MAX_WINDOW][MAX_WINDOW];
    logic [PIXEL_BITS-1:0] new_row [MAX_WINDOW];

    always_comb begin
        logic [WS_W-1:0] d;
        logic [T_W-1:0]  t;
        for (int w = 0; w < MAX_WINDOW; w++) begin
            d = r1_ww - 1'b1 - WS_W'(w);
            t = T_W'(r1_slot) + T_W'(SLOTS) - T_W'(d);
            if (t >= T_W'(SLOTS))
                t = t - T_W'(SLOTS);
            if (WS_W'(w) == r1_ww - 1'b1)
                new_row[w] = r1_pix;
            else if (WS_W'(w) < r1_ww - 1'b1)
                new_row[w] = r_rd[t[SLOT_W-1:0]];
            else
                new_row[w] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r1_valid) begin
            for (int h = 0; h < MAX_WINDOW - 1; h++)
                r_win[h] <= r_win[h+1];
            r_win[MAX_WINDOW-1] <= new_row;
        end
    end

    logic                  r2_valid;
    logic [WS_W-1:0]       r2_ww;
    logic [WS_W-1:0]       r2_wh;
    logic                  r2_last;
    logic [COL_W-1:0]      r2_ccol;
    logic [ROW_W-1:0]      r2_crow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (advance) begin
            r2_valid <= r1_valid && r1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r2_ww   <= r1_ww;
            r2_wh   <= r1_wh;
            r2_last <= r1_last;
            r2_ccol <= r1_ccol;
            r2_crow <= r1_crow;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: rank of every window value (ties broken by position)
    // ------------------------------------------------------------------
    logic [PIXEL_BITS-1:0] vals [NVAL];
    logic [NVAL-1:0]       mask;
    logic [CNT_W-1:0]      rank [NVAL];
    logic [2*WS_W-1:0]     n_count;

    always_comb begin
        logic [NVAL-1:0] below;
        for (int k = 0; k < NVAL; k++) begin
            vals[k] = r_win[k / MAX_WINDOW][k % MAX_WINDOW];
            mask[k] = ((k / MAX_WINDOW) >= (MAX_WINDOW - int'(r2_wh)))
                   && ((k % MAX_WINDOW) < int'(r2_ww));
        end
        // count the values ranked ahead of each one as a population count
        for (int k = 0; k < NVAL; k++) begin
            for (int j = 0; j < NVAL; j++)
                below[j] = mask[j]
                        && ((vals[j] < vals[k]) || ((vals[j] == vals[k]) && (j < k)));
            rank[k] = CNT_W'($countones(below));
        end
        n_count = (2*WS_W)'(r2_ww) * (2*WS_W)'(r2_wh);
    end

    logic                  r3_valid;
    logic [PIXEL_BITS-1:0] r3_vals [NVAL];
    logic [NVAL-1:0]       r3_mask;
    logic [CNT_W-1:0]      r3_rank [NVAL];
    logic [CNT_W-1:0]      r3_target;
    logic                  r3_last;
    logic [COL_W-1:0]      r3_ccol;
    logic [ROW_W-1:0]      r3_crow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (advance) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r3_vals   <= vals;
            r3_mask   <= mask;
            r3_rank   <= rank;
            r3_target <= CNT_W'((n_count - 1'b1) >> 1);
            r3_last   <= r2_last;
            r3_ccol   <= r2_ccol;
            r3_crow   <= r2_crow;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: pick the value whose rank is the middle one
    // ------------------------------------------------------------------
    logic [NVAL-1:0]       sel;
    logic [PIXEL_BITS-1:0] median;

    always_comb begin
        median = '0;
        for (int k = 0; k < NVAL; k++) begin
            sel[k] = r3_mask[k] && (r3_rank[k] == r3_target);
            if (sel[k])
                median = median | r3_vals[k];
        end
    end

    logic [PIXEL_BITS-1:0] r_out_median;
    logic [COL_W-1:0]      r_out_ccol;
    logic [ROW_W-1:0]      r_out_crow;
    logic                  r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_median <= median;
            r_out_ccol   <= r3_ccol;
            r_out_crow   <= r3_crow;
            r_out_last   <= r3_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_median_value = r_out_median;
    assign o_centre_col   = r_out_ccol;
    assign o_centre_row   = r_out_crow;
    assign o_frame_last   = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_unique_median: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r3_valid |-> $onehot(sel))
        else $error("median select is not one-hot");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_slot) < SLOTS)
        else $error("column slot out of range");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_frame_start && rows_eff > (ROW_W+1)'(1)) |=>
            (r_row_pos == ROW_W'(1)) && (r_col_pos == '0) && (r_slot == '0))
        else $error("frame start did not restart the position");

    a_no_stall_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> !o_stall)
        else $error("input stalled with an empty output register");

endmodule

@@ tb/sv/window_median_filter_2d_tb.sv @@
`timescale 1ns / 1ps

module window_median_filter_2d_tb;
    import wmf_pkg::*;

    localparam int MAX_ROWS   = 1024;
    localparam int MAX_COLS   = 4096;
    localparam int MAX_WINDOW = 7;
    localparam int PIXEL_BITS = 16;
    localparam int STORE_COLS = MAX_WINDOW - 1;
    localparam int ODD_MAX    = (MAX_WINDOW - 1) | 1;
    localparam int TARGET     = 1750;
    localparam int DRAIN      = 12;
    localparam int LIMIT      = 300000;

    typedef struct packed {
        logic [15:0] pixel;
        logic        frame_start;
    } t_pixel_word;

    typedef struct packed {
        logic [15:0] median_value;
        logic [11:0] centre_col;
        logic [9:0]  centre_row;
        logic        frame_last;
    } t_median_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [PIXEL_BITS-1:0] i_pixel = '0;
    logic        i_frame_start = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [PIXEL_BITS-1:0] o_median_value;
    logic [11:0] o_centre_col;
    logic [9:0]  o_centre_row;
    logic        o_frame_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    window_median_filter_2d uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel        (i_pixel),
        .i_frame_start  (i_frame_start),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_median_value (o_median_value),
        .o_centre_col   (o_centre_col),
        .o_centre_row   (o_centre_row),
        .o_frame_last   (o_frame_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the filter: line stores, window, position and registers.
    logic [15:0] line_store [STORE_COLS*MAX_ROWS];
    logic [15:0] win_regs [MAX_WINDOW*MAX_WINDOW];
    int unsigned next_row, next_col;
    logic [10:0] reg_rows;
    logic [12:0] reg_cols;
    logic [2:0]  reg_ww, reg_wh;

    t_pixel_word  pixels_to_send [$];
    t_median_word pending_medians [$];

    int gap_pct = 0;
    int stall_pct = 0;
    bit hold_go = 1'b0;
    bit hold_on = 1'b0;
    bit took = 1'b0;
    int n_pixels = 0;
    int n_medians = 0;
    int n_errors = 0;
    int n_phases = 0;
    int unsigned cycle = 0;

    // Advance the shadow filter by one pixel word; queue a median if the
    // window lies fully inside the image.
    task automatic median_step(input logic [15:0] pix, input logic fs);
        int unsigned rows, cols, ww, wh, row, col, slot, n, i, j, h, w, v;
        int unsigned vals [MAX_WINDOW*MAX_WINDOW];
        t_median_word res;
        rows = (reg_rows == 0) ? 1 : (reg_rows > MAX_ROWS ? MAX_ROWS : reg_rows);
        cols = (reg_cols == 0) ? 1 : (reg_cols > MAX_COLS ? MAX_COLS : reg_cols);
        ww = reg_ww | 1;
        if (ww > ODD_MAX) ww = ODD_MAX;
        wh = reg_wh | 1;
        if (wh > ODD_MAX) wh = ODD_MAX;
        if (fs) begin
            next_row = 0;
            next_col = 0;
        end
        if (next_row >= rows) begin
            next_row = 0;
            next_col++;
        end
        if (next_col >= cols) next_col = 0;
        row = next_row;
        col = next_col;
        // shift the window up by one row
        for (h = 0; h + 1 < MAX_WINDOW; h++)
            for (w = 0; w < MAX_WINDOW; w++)
                win_regs[h*MAX_WINDOW + w] = win_regs[(h+1)*MAX_WINDOW + w];
        for (i = 1; i < ww; i++) begin
            slot = (col % STORE_COLS + STORE_COLS - i) % STORE_COLS;
            win_regs[(MAX_WINDOW-1)*MAX_WINDOW + (ww-1-i)] = line_store[slot*MAX_ROWS + row];
        end
        win_regs[(MAX_WINDOW-1)*MAX_WINDOW + (ww-1)] = pix;
        line_store[(col % STORE_COLS)*MAX_ROWS + row] = pix;
        if (col + 1 >= ww && row + 1 >= wh) begin
            n = 0;
            for (h = MAX_WINDOW - wh; h < MAX_WINDOW; h++)
                for (w = 0; w < ww; w++) begin
                    vals[n] = 32'(win_regs[h*MAX_WINDOW + w]);
                    n++;
                end
            for (i = 1; i < n; i++) begin
                v = vals[i];
                j = i;
                while (j > 0 && vals[j-1] > v) begin
                    vals[j] = vals[j-1];
                    j--;
                end
                vals[j] = v;
            end
            res.median_value = 16'(vals[(n-1)/2]);
            res.centre_col   = 12'(col - ww/2);
            res.centre_row   = 10'(row - wh/2);
            res.frame_last   = (row + 1 == rows) && (col + 1 == cols);
            pending_medians.push_back(res);
        end
        row++;
        if (row >= rows) begin
            row = 0;
            col++;
            if (col >= cols) col = 0;
        end
        next_row = row;
        next_col = col;
    endtask

    // Accept side: predict on every word taken, count cycles, enforce limit.
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
        took <= i_valid && !o_stall && i_rst_n;
        if (i_rst_n && i_valid && !o_stall) begin
            median_step(i_pixel, i_frame_start);
            n_pixels++;
        end
    end

    // Driver: present the next word after the previous one was taken.
    always @(negedge i_clk) begin
        t_pixel_word wd;
        if (i_rst_n && (!i_valid || took)) begin
            if (pixels_to_send.size() > 0 && $urandom_range(99) >= gap_pct) begin
                wd = pixels_to_send.pop_front();
                i_pixel       <= wd.pixel;
                i_frame_start <= wd.frame_start;
                i_valid       <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure; hold fully while a long hold-off runs.
    always @(negedge i_clk) begin
        i_stall <= hold_on || ($urandom_range(99) < stall_pct);
    end

    // Long hold-off, counted here, so the pipeline backs up into the input.
    always begin
        wait (hold_go);
        hold_on = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_on = 1'b0;
        hold_go = 1'b0;
    end

    // Monitor: compare every result word with the oldest prediction.
    always @(posedge i_clk) begin
        t_median_word got, exp_w;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_median_value, o_centre_col, o_centre_row, o_frame_last};
            n_medians++;
            if (pending_medians.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result word: median %0d col %0d row %0d last %0b",
                             got.median_value, got.centre_col, got.centre_row,
                             got.frame_last);
            end else begin
                exp_w = pending_medians.pop_front();
                if (got !== exp_w) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                                 exp_w.median_value, exp_w.centre_col, exp_w.centre_row,
                                 exp_w.frame_last, got.median_value, got.centre_col,
                                 got.centre_row, got.frame_last);
                end
            end
        end
    end

    // Write one register; update the shadow copy on the accepting edge.
    task automatic write_reg(input t_cfg_index idx, input int unsigned val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_IMAGE_ROWS:    reg_rows = 11'(val);
            CFG_IMAGE_COLS:    reg_cols = 13'(val);
            CFG_WINDOW_WIDTH:  reg_ww = 3'(val);
            CFG_WINDOW_HEIGHT: reg_wh = 3'(val);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_geometry(input int unsigned rows, cols, ww, wh);
        write_reg(CFG_IMAGE_ROWS, rows);
        write_reg(CFG_IMAGE_COLS, cols);
        write_reg(CFG_WINDOW_WIDTH, ww);
        write_reg(CFG_WINDOW_HEIGHT, wh);
    endtask

    // Drain the pipeline: nothing left to send, nothing predicted outstanding.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (pixels_to_send.size() != 0 || i_valid || pending_medians.size() != 0);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_pixel();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(15));
            default: return 16'($urandom);
        endcase
    endfunction

    // Queue one frame, cut short after max_len words (frame_start on word 0).
    task automatic queue_frame(input int unsigned rows, cols, max_len);
        int unsigned r, c, total, k;
        t_pixel_word wd;
        r = (rows == 0) ? 1 : (rows > MAX_ROWS ? MAX_ROWS : rows);
        c = (cols == 0) ? 1 : (cols > MAX_COLS ? MAX_COLS : cols);
        total = r * c;
        if (total > max_len) total = max_len;
        for (k = 0; k < total; k++) begin
            wd.pixel = rand_pixel();
            wd.frame_start = (k == 0);
            pixels_to_send.push_back(wd);
        end
    endtask

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 61; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 61; end
            default: begin gap_pct = 10; stall_pct = 10; end
        endcase
    endtask

    initial begin
        int unsigned k, rows, cols, ww, wh, frames;
        t_pixel_word wd;
        next_row = 0;
        next_col = 0;
        reg_rows = ROWS_RESET;
        reg_cols = COLS_RESET;
        reg_ww   = WIN_RESET;
        reg_wh   = WIN_RESET;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a 5 by 5 frame with a 3 by 3 window and extreme samples.
        set_geometry(5, 5, 3, 3);
        for (k = 0; k < 25; k++) begin
            case (k % 5)
                0: wd.pixel = 16'h0000;
                1: wd.pixel = 16'hFFFF;
                2: wd.pixel = 16'h5555;
                3: wd.pixel = 16'hAAAA;
                default: wd.pixel = 16'($urandom);
            endcase
            wd.frame_start = (k == 0);
            pixels_to_send.push_back(wd);
        end
        wait_idle();

        // Zero sizes act as one: every pixel of a single-row image is a median.
        set_geometry(0, 9, 0, 0);
        repeat (3) queue_frame(0, 9, 9);
        wait_idle();

        // Oversized rows clamp to the maximum; tall window, partial frame.
        set_idling(1);
        set_geometry(2047, 3, 1, 7);
        queue_frame(2047, 3, 300);
        wait_idle();

        // Oversized columns clamp; widest window, even height rounds up.
        set_idling(2);
        set_geometry(7, 8191, 7, 2);
        queue_frame(7, 8191, 250);
        wait_idle();

        // Window larger than the image yields nothing.
        set_idling(3);
        set_geometry(3, 4, 7, 7);
        repeat (2) queue_frame(3, 4, 12);
        wait_idle();

        // Pressure: long hold-off while the sender keeps pushing.
        set_idling(0);
        set_geometry(6, 40, 4, 6);
        hold_go = 1'b1;
        queue_frame(6, 40, 240);
        wait_idle();
        n_phases = 6;

        // Random geometries, cycling the idling patterns.
        while (n_pixels < TARGET) begin
            rows = $urandom_range(1, 20);
            cols = $urandom_range(1, 20);
            ww = $urandom_range(7);
            wh = $urandom_range(7);
            if ($urandom_range(9) == 0) rows = 0;
            if ($urandom_range(9) == 0) cols = 0;
            set_idling(n_phases);
            set_geometry(rows, cols, ww, wh);
            frames = $urandom_range(1, 3);
            repeat (frames) begin
                // mostly whole frames, sometimes cut short by the next start
                if ($urandom_range(4) == 0)
                    queue_frame(rows, cols, $urandom_range(1, 60));
                else
                    queue_frame(rows, cols, 400);
            end
            wait_idle();
            n_phases++;
        end

        $display("Covered %0d pixel words and %0d median words over %0d configurations,",
                 n_pixels, n_medians, n_phases);
        $display("with clamped sizes, even and oversized windows, and stall patterns.");
        if (n_errors == 0 && pending_medians.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ window_median_filter_2d.f @@
src/wmf_pkg.sv
src/window_median_filter_2d.sv
tb/sv/window_median_filter_2d_tb.sv
